// ----- rtl/dtp_pkg.sv -----
// ----------------------------------------------------------------------------
// dtp_pkg
// Shared types and constants for the device tree token parser.
// ----------------------------------------------------------------------------
package dtp_pkg;

  localparam int MAX_DEPTH = 255;
  localparam logic [7:0] DEPTH_CAP = (MAX_DEPTH > 255) ? 8'd255 : 8'(MAX_DEPTH);

  localparam logic [31:0] DT_MAGIC = 32'hD00DFEED;

  localparam logic [31:0] TOK_BEGIN_NODE = 32'd1;
  localparam logic [31:0] TOK_END_NODE   = 32'd2;
  localparam logic [31:0] TOK_PROP       = 32'd3;
  localparam logic [31:0] TOK_NOP        = 32'd4;
  localparam logic [31:0] TOK_END        = 32'd9;

  localparam logic [31:0] POS_STRUCT_OFF  = 32'd8;
  localparam logic [31:0] POS_STRINGS_OFF = 32'd12;
  localparam logic [31:0] POS_STRUCT_SIZE = 32'd36;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_SKIP   = 3'd1,
    PH_TOKEN  = 3'd2,
    PH_NAME   = 3'd3,
    PH_PLEN   = 3'd4,
    PH_PNAME  = 3'd5,
    PH_DATA   = 3'd6,
    PH_DONE   = 3'd7
  } phase_t;

  typedef enum logic [3:0] {
    EV_BEGIN_NODE = 4'd0,
    EV_NAME_WORD  = 4'd1,
    EV_END_NODE   = 4'd2,
    EV_PROP       = 4'd3,
    EV_DATA_WORD  = 4'd4,
    EV_NOP        = 4'd5,
    EV_END        = 4'd6,
    EV_BAD_MAGIC  = 4'd7,
    EV_BAD_TOKEN  = 4'd8
  } event_kind_t;

  typedef struct packed {
    event_kind_t kind;
    logic [31:0] value;
    logic [31:0] name_offset;
    logic        last;
    logic [7:0]  depth;
  } result_t;

endpackage

// ----- rtl/device_tree_token_parser.sv -----
// ----------------------------------------------------------------------------
// device_tree_token_parser
// Streaming flattened device tree structure tokenizer.
// ----------------------------------------------------------------------------
// Input stream: one big-endian blob word per transaction in s_axis_tdata;
// s_axis_tuser marks word zero of a new blob and restarts parsing.
// The header magic is checked, the structure offset, strings offset and
// structure size are captured, and the structure block is turned into
// events on the output stream: kind in m_axis_tuser, value, name offset
// and nest depth in m_axis_tdata, m_axis_tlast ending name and data runs.
// Most words give one event; header words other than a bad magic, skipped
// words, property tokens, property lengths and words at or past the
// structure end give none. After a bad magic or an unknown token no more
// events come until the next start word. Events pass the input register,
// then the two-entry result buffer. Throughput: one word per cycle while
// the result buffer is not full.
// When the receiver stalls the buffer fills and s_axis_tready drops.
// Reset clears the parser state, as at a start word, and empties the buffer.
// ----------------------------------------------------------------------------
module device_tree_token_parser
  import dtp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // blob_word
  input  logic        s_axis_tuser,  // start_of_blob
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // event_value, name_offset, nest_depth
  output logic        m_axis_tlast,  // last_of_run
  output logic [3:0]  m_axis_tuser   // event_kind
);

  logic        in_valid;
  logic [31:0] in_word;
  logic        in_start;
  logic        take;
  logic        buf_full;
  logic        emit;
  result_t     res;

  assign take          = in_valid && !buf_full;
  assign s_axis_tready = !in_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_word  <= s_axis_tdata;
      in_start <= s_axis_tuser;
    end
  end

  dtp_step u_step (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .item_word  (in_word),
    .item_start (in_start),
    .emit       (emit),
    .res        (res)
  );

  dtp_out_buf u_out_buf (
    .clk           (clk),
    .rst           (rst),
    .push          (take && emit),
    .din           (res),
    .full          (buf_full),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ----- rtl/dtp_step.sv -----
// ----------------------------------------------------------------------------
// dtp_step
// Parser state and the per-word step: header capture, structure tokenizing.
// ----------------------------------------------------------------------------
module dtp_step
  import dtp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [31:0] item_word,
  input  logic        item_start,
  output logic        emit,
  output result_t     res
);

  logic [31:0] byte_position, byte_position_next;
  logic [31:0] struct_start, struct_start_next;
  logic [31:0] struct_end, struct_end_next;
  logic [31:0] strings_base, strings_base_next;
  phase_t      phase, phase_next;
  logic [31:0] prop_length, prop_length_next;
  logic [29:0] data_words_left, data_words_left_next;
  logic [7:0]  depth_count, depth_count_next;
  logic        halted, halted_next;

  logic [31:0] cur_pos;
  logic [31:0] cur_sstart;
  logic [31:0] cur_send;
  logic [31:0] cur_sbase;
  phase_t      cur_phase;
  logic [31:0] cur_plen;
  logic [29:0] cur_left;
  logic [7:0]  cur_depth;
  logic        cur_halted;
  logic        do_token;
  logic        has_zero;
  logic [30:0] word_count;

  always_comb begin
    cur_pos    = item_start ? 32'd0 : byte_position;
    cur_sstart = item_start ? 32'd0 : struct_start;
    cur_send   = item_start ? 32'd0 : struct_end;
    cur_sbase  = item_start ? 32'd0 : strings_base;
    cur_phase  = item_start ? PH_HEADER : phase;
    cur_plen   = item_start ? 32'd0 : prop_length;
    cur_left   = item_start ? 30'd0 : data_words_left;
    cur_depth  = item_start ? 8'd0 : depth_count;
    cur_halted = item_start ? 1'b0 : halted;

    has_zero = (item_word[31:24] == 8'd0) || (item_word[23:16] == 8'd0) ||
               (item_word[15:8] == 8'd0) || (item_word[7:0] == 8'd0);
    word_count = {1'b0, cur_plen[31:2]} + {30'd0, |cur_plen[1:0]};

    byte_position_next   = cur_pos;
    struct_start_next    = cur_sstart;
    struct_end_next      = cur_send;
    strings_base_next    = cur_sbase;
    phase_next           = cur_phase;
    prop_length_next     = cur_plen;
    data_words_left_next = cur_left;
    depth_count_next     = cur_depth;
    halted_next          = cur_halted;
    do_token             = 1'b0;

    emit            = 1'b0;
    res.kind        = EV_NOP;
    res.value       = 32'd0;
    res.name_offset = 32'd0;
    res.last        = 1'b0;
    res.depth       = cur_depth;

    if (!cur_halted) begin
      byte_position_next = cur_pos + 32'd4;
      unique case (cur_phase)
        PH_HEADER: begin
          if (cur_pos == 32'd0 && item_word != DT_MAGIC) begin
            halted_next = 1'b1;
            emit        = 1'b1;
            res.kind    = EV_BAD_MAGIC;
          end else if (cur_pos == POS_STRUCT_OFF) begin
            struct_start_next = item_word;
          end else if (cur_pos == POS_STRINGS_OFF) begin
            strings_base_next = item_word;
          end else if (cur_pos == POS_STRUCT_SIZE) begin
            struct_end_next = cur_sstart + item_word;
            phase_next      = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (cur_pos >= cur_sstart) begin
            phase_next = PH_TOKEN;
            do_token   = 1'b1;
          end
        end
        PH_TOKEN: do_token = 1'b1;
        PH_NAME: begin
          if (has_zero) phase_next = PH_TOKEN;
          emit      = 1'b1;
          res.kind  = EV_NAME_WORD;
          res.value = item_word;
          res.last  = has_zero;
        end
        PH_PLEN: begin
          prop_length_next = item_word;
          phase_next       = PH_PNAME;
        end
        PH_PNAME: begin
          emit            = 1'b1;
          res.kind        = EV_PROP;
          res.name_offset = cur_sbase + item_word;
          if (word_count == 31'd0) begin
            phase_next = PH_TOKEN;
            res.last   = 1'b1;
          end else begin
            data_words_left_next = 30'(word_count - 31'd1);
            phase_next           = PH_DATA;
            res.value            = cur_plen;
          end
        end
        PH_DATA: begin
          emit      = 1'b1;
          res.kind  = EV_DATA_WORD;
          res.value = item_word;
          if (cur_left == 30'd0) begin
            phase_next = PH_TOKEN;
            res.last   = 1'b1;
          end else begin
            data_words_left_next = cur_left - 30'd1;
          end
        end
        PH_DONE: ;
        default: ;
      endcase

      if (do_token) begin
        if (cur_pos >= cur_send) begin
          phase_next = PH_DONE;
        end else begin
          emit = 1'b1;
          unique case (item_word)
            TOK_BEGIN_NODE: begin
              if (cur_depth < DEPTH_CAP) depth_count_next = cur_depth + 8'd1;
              phase_next = PH_NAME;
              res.kind   = EV_BEGIN_NODE;
              res.depth  = cur_depth;
            end
            TOK_END_NODE: begin
              if (cur_depth != 8'd0) depth_count_next = cur_depth - 8'd1;
              res.kind  = EV_END_NODE;
              res.depth = (cur_depth != 8'd0) ? cur_depth - 8'd1 : 8'd0;
            end
            TOK_PROP: begin
              phase_next = PH_PLEN;
              emit       = 1'b0;
            end
            TOK_NOP: res.kind = EV_NOP;
            TOK_END: res.kind = EV_END;
            default: begin
              halted_next = 1'b1;
              res.kind    = EV_BAD_TOKEN;
              res.value   = item_word;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= 32'd0;
      struct_start    <= 32'd0;
      struct_end      <= 32'd0;
      strings_base    <= 32'd0;
      phase           <= PH_HEADER;
      prop_length     <= 32'd0;
      data_words_left <= 30'd0;
      depth_count     <= 8'd0;
      halted          <= 1'b0;
    end else if (take) begin
      byte_position   <= byte_position_next;
      struct_start    <= struct_start_next;
      struct_end      <= struct_end_next;
      strings_base    <= strings_base_next;
      phase           <= phase_next;
      prop_length     <= prop_length_next;
      data_words_left <= data_words_left_next;
      depth_count     <= depth_count_next;
      halted          <= halted_next;
    end
  end

  a_halted_silent: assert property (@(posedge clk) disable iff (rst)
    take && halted && !item_start |-> !emit)
    else $error("event while halted");

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    take && phase == PH_DONE && !item_start |-> !emit)
    else $error("event after structure end");

  a_error_halts: assert property (@(posedge clk) disable iff (rst)
    take && emit && (res.kind == EV_BAD_MAGIC || res.kind == EV_BAD_TOKEN) |=> halted)
    else $error("error event did not halt");

  a_pos_advance: assert property (@(posedge clk) disable iff (rst)
    take && !halted && !item_start |=> byte_position == $past(byte_position) + 32'd4)
    else $error("byte position did not advance");

endmodule

// ----- rtl/dtp_out_buf.sv -----
// ----------------------------------------------------------------------------
// dtp_out_buf
// Two-entry result buffer; decouples the parser from output stalls.
// ----------------------------------------------------------------------------
module dtp_out_buf
  import dtp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  result_t     din,
  output logic        full,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // event_value, name_offset, nest_depth
  output logic        m_axis_tlast,  // last_of_run
  output logic [3:0]  m_axis_tuser   // event_kind
);

  result_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       pop;
  result_t    head;

  assign head          = mem[rd_ptr];
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign full          = (count == 2'd2);
  assign m_axis_tvalid = (count != 2'd0);
  assign m_axis_tdata  = {head.depth, head.name_offset, head.value};
  assign m_axis_tlast  = head.last;
  assign m_axis_tuser  = head.kind;

  always_comb begin
    count_next = count;
    if (push && !pop) count_next = count + 2'd1;
    else if (!push && pop) count_next = count - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

endmodule
